@@ src/fdtd_pkg.sv @@
package fdtd_pkg;

  // command codes of an input transaction
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // result kinds
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // grid select codes
  localparam logic [1:0] FIELD_HX = 2'd0;
  localparam logic [1:0] FIELD_EY = 2'd1;
  localparam logic [1:0] FIELD_EZ = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_H_UPDATE_GAIN = 3'd0;
  localparam logic [2:0] REG_E_DECAY_GAIN  = 3'd1;
  localparam logic [2:0] REG_E_UPDATE_GAIN = 3'd2;
  localparam logic [2:0] REG_SOURCE_ROW    = 3'd3;
  localparam logic [2:0] REG_SOURCE_COL    = 3'd4;

  // configuration reset values
  localparam logic [31:0] H_UPDATE_GAIN_RST = 32'd42945378;
  localparam logic [31:0] E_DECAY_GAIN_RST  = 32'd2147483646;
  localparam logic [31:0] E_UPDATE_GAIN_RST = 32'd42953109;
  localparam logic [5:0]  SOURCE_ROW_RST    = 6'd21;
  localparam logic [5:0]  SOURCE_COL_RST    = 6'd21;

  typedef struct packed {
    logic               command;
    logic signed [31:0] source_value;
    logic [1:0]         field_select;
    logic [5:0]         cell_row;
    logic [5:0]         cell_col;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] field_value;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SOURCE,
    ST_HPASS,
    ST_EPASS,
    ST_READ,
    ST_FINISH
  } state_t;

endpackage

@@ src/fdtd_grid_ram.sv @@
module fdtd_grid_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fdtd_gmul.sv @@
module fdtd_gmul #(
  parameter int VB = 32
) (
  input  logic                 clk,
  input  logic [31:0]          gain,
  input  logic signed [VB-1:0] value,
  output logic signed [VB-1:0] product
);

  localparam logic [64:0] VMAX = (65'd1 << (VB - 1)) - 65'd1;

  logic          neg0;
  logic [VB-1:0] mag0;
  logic [63:0]   m64;
  logic [31:0]   g1;
  logic [31:0]   mlo1;
  logic [31:0]   mhi1;
  logic          neg1;
  logic [63:0]   p2;
  logic [63:0]   q2;
  logic          neg2;
  logic [64:0]   r2;
  logic signed [VB-1:0] y2;

  // magnitude and sign of the operand
  always_comb begin
    neg0 = value[VB-1];
    mag0 = neg0 ? (VB'(0) - value) : value;
    m64  = 64'(mag0);
  end

  // stage 1: split magnitude into two 32-bit halves
  always_ff @(posedge clk) begin
    g1   <= gain;
    mlo1 <= m64[31:0];
    mhi1 <= m64[63:32];
    neg1 <= neg0;
  end

  // stage 2: partial products, rounding term on the low half
  always_ff @(posedge clk) begin
    p2   <= 64'(g1) * 64'(mlo1) + (64'd1 << 30);
    q2   <= 64'(g1) * 64'(mhi1);
    neg2 <= neg1;
  end

  // recombine, rescale by 2^-31 and saturate
  always_comb begin
    r2 = {q2, 1'b0} + 65'(p2 >> 31);
    if (q2[63:62] != 2'b00) begin
      y2 = neg2 ? VB'(~VMAX) : VB'(VMAX);
    end else if (neg2) begin
      y2 = (r2 > VMAX) ? VB'(~VMAX) : VB'(65'd0 - r2);
    end else begin
      y2 = (r2 > VMAX) ? VB'(VMAX) : VB'(r2);
    end
  end

  // stage 3: registered product
  always_ff @(posedge clk) begin
    product <= y2;
  end

endmodule

@@ src/fdtd_2d_te_grid_update.sv @@
// 2d te yee grid engine with hx, ey and ez held in three on-chip memories
// item channel (item_valid/item_ready/item) takes step and read commands;
// result channel (result_valid/result_ready/result) returns one transaction
// per command: an acknowledgement for a step, the cell value for a read
// configuration is to be written through cfg_write/cfg_index/cfg_data by
// the user only while idle; the block itself leaves this unchecked
// after reset the three grids are cleared, one cell a cycle; no item is
// taken meanwhile
// a read passes through the read and finish states before its result is
// registered; a step writes the source cell, then sweeps h and then e over
// every cell, each cell update paced by the single read port of each grid
// memory and the 3-stage shared gain multiplier
// one command is worked on at a time; the result sits in an output register,
// so a stalled receiver holds that register and the next command is
// accepted while the result waits; a later result waits in the finish state
module fdtd_2d_te_grid_update #(
  parameter int GRID_ROWS  = 64,
  parameter int GRID_COLS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  fdtd_pkg::item_t  item,
  output logic             result_valid,
  input  logic             result_ready,
  output fdtd_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  import fdtd_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam logic signed [65:0] VMAX66 = (66'sd1 <<< (VB - 1)) - 66'sd1;
  localparam logic signed [65:0] VMIN66 = -VMAX66 - 66'sd1;
  localparam logic signed [65:0] MAX32  = 66'sd2147483647;
  localparam logic signed [65:0] MIN32  = -66'sd2147483648;

  // saturating add or subtract on grid values
  function automatic logic signed [VB-1:0] sat_as(input logic signed [VB-1:0] a,
                                                 input logic signed [VB-1:0] b,
                                                 input logic sub);
    logic signed [VB:0] s;
    s = sub ? ({a[VB-1], a} - {b[VB-1], b}) : ({a[VB-1], a} + {b[VB-1], b});
    if (s[VB] != s[VB-1]) begin
      return s[VB] ? VB'(VMIN66) : VB'(VMAX66);
    end
    return s[VB-1:0];
  endfunction

  state_t state, state_next;

  logic [31:0] h_update_gain;
  logic [31:0] e_decay_gain;
  logic [31:0] e_update_gain;
  logic [5:0]  source_row;
  logic [5:0]  source_col;

  logic [AW-1:0] k;
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [3:0]    ph;

  logic               cmd;
  logic signed [VB-1:0] src_val;
  logic [1:0]         rd_sel;
  logic               rd_in_grid;
  logic [AW-1:0]      rd_addr;

  logic signed [VB-1:0] hx0, ey0, ez0, dy, dz, curl, hz, hy, dey, dez;

  logic          hx_we, ey_we, ez_we;
  logic [AW-1:0] hx_waddr;
  logic [VB-1:0] hx_wdata, ey_wdata, ez_wdata;
  logic [AW-1:0] hx_raddr, ey_raddr, ez_raddr;
  logic signed [VB-1:0] hx_rd, ey_rd, ez_rd;

  logic [31:0]          mul_g;
  logic signed [VB-1:0] mul_v;
  logic signed [VB-1:0] mul_y;

  logic          accept, out_free, last_cell, h_edge, e_edge, cell_done;
  logic          src_in_grid;
  logic [AW-1:0] src_addr;
  logic signed [65:0] src_ext, rd_ext;
  logic signed [VB-1:0] src_clamped, rd_pick;
  logic signed [31:0] rd_value;

  // grid memories and shared multiplier
  fdtd_grid_ram #(.DEPTH(CELLS), .WIDTH(VB), .AW(AW)) u_hx (
    .clk(clk), .we(hx_we), .waddr(hx_waddr), .wdata(hx_wdata),
    .raddr(hx_raddr), .rdata(hx_rd)
  );
  fdtd_grid_ram #(.DEPTH(CELLS), .WIDTH(VB), .AW(AW)) u_ey (
    .clk(clk), .we(ey_we), .waddr(k), .wdata(ey_wdata),
    .raddr(ey_raddr), .rdata(ey_rd)
  );
  fdtd_grid_ram #(.DEPTH(CELLS), .WIDTH(VB), .AW(AW)) u_ez (
    .clk(clk), .we(ez_we), .waddr(k), .wdata(ez_wdata),
    .raddr(ez_raddr), .rdata(ez_rd)
  );
  fdtd_gmul #(.VB(VB)) u_gmul (
    .clk(clk), .gain(mul_g), .value(mul_v), .product(mul_y)
  );

  // sweep position and handshake status
  always_comb begin
    accept      = item_valid && item_ready;
    out_free    = !result_valid || result_ready;
    last_cell   = (k == AW'(CELLS - 1));
    h_edge      = (r == RW'(GRID_ROWS - 1)) || (c == CW'(GRID_COLS - 1));
    e_edge      = (r == '0) || (c == '0) || h_edge;
    cell_done   = (state == ST_HPASS) ? (h_edge || ph == 4'd7) : (e_edge || ph == 4'd8);
    item_ready  = (state == ST_IDLE);
    src_in_grid = (32'(source_row) < GRID_ROWS) && (32'(source_col) < GRID_COLS);
    src_addr    = AW'(32'(source_row) * GRID_COLS + 32'(source_col));
  end

  // source value widened and saturated to the grid range
  always_comb begin
    src_ext = 66'(item.source_value);
    if (src_ext > VMAX66) begin
      src_clamped = VB'(VMAX66);
    end else if (src_ext < VMIN66) begin
      src_clamped = VB'(VMIN66);
    end else begin
      src_clamped = VB'(src_ext);
    end
  end

  // read data selection and saturation to 32 bits
  always_comb begin
    case (rd_sel)
      FIELD_HX: rd_pick = hx_rd;
      FIELD_EY: rd_pick = ey_rd;
      FIELD_EZ: rd_pick = ez_rd;
      default:  rd_pick = '0;
    endcase
    if (!rd_in_grid) begin
      rd_pick = '0;
    end
    rd_ext = 66'(rd_pick);
    if (rd_ext > MAX32) begin
      rd_value = 32'(MAX32);
    end else if (rd_ext < MIN32) begin
      rd_value = 32'(MIN32);
    end else begin
      rd_value = 32'(rd_ext);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (last_cell) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_next = (item.command == CMD_STEP) ? ST_SOURCE : ST_READ;
      end
      ST_SOURCE: state_next = ST_HPASS;
      ST_HPASS:  if (cell_done && last_cell) state_next = ST_EPASS;
      ST_EPASS:  if (cell_done && last_cell) state_next = ST_FINISH;
      ST_READ:   state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // memory ports and multiplier operands
  always_comb begin
    hx_raddr = k;
    ey_raddr = k;
    ez_raddr = k;
    hx_we    = 1'b0;
    ey_we    = 1'b0;
    ez_we    = 1'b0;
    hx_waddr = k;
    hx_wdata = '0;
    ey_wdata = '0;
    ez_wdata = '0;
    mul_g    = '0;
    mul_v    = '0;
    unique case (state)
      ST_CLEAR: begin
        hx_we = 1'b1;
        ey_we = 1'b1;
        ez_we = 1'b1;
      end
      ST_SOURCE: begin
        hx_we    = src_in_grid;
        hx_waddr = src_addr;
        hx_wdata = src_val;
      end
      ST_HPASS: begin
        if (ph == 4'd1) begin
          ey_raddr = k + AW'(1);
          ez_raddr = k + AW'(GRID_COLS);
        end
        if (ph == 4'd4) begin
          mul_g = h_update_gain;
          mul_v = curl;
        end
        if (h_edge) begin
          hx_we = 1'b1;
        end else if (ph == 4'd7) begin
          hx_we    = 1'b1;
          hx_wdata = sat_as(hx0, mul_y, 1'b0);
        end
      end
      ST_EPASS: begin
        if (ph == 4'd1) hx_raddr = k - AW'(GRID_COLS);
        if (ph == 4'd2) hx_raddr = k - AW'(1);
        case (ph)
          4'd2: begin mul_g = e_decay_gain;  mul_v = ey0; end
          4'd3: begin mul_g = e_decay_gain;  mul_v = ez0; end
          4'd4: begin mul_g = e_update_gain; mul_v = hz;  end
          4'd5: begin mul_g = e_update_gain; mul_v = hy;  end
          default: ;
        endcase
        if (e_edge) begin
          ey_we = 1'b1;
          ez_we = 1'b1;
        end else if (ph == 4'd7) begin
          ez_we    = 1'b1;
          ez_wdata = sat_as(dez, mul_y, 1'b0);
        end else if (ph == 4'd8) begin
          ey_we    = 1'b1;
          ey_wdata = sat_as(dey, mul_y, 1'b0);
        end
      end
      ST_READ, ST_FINISH: begin
        hx_raddr = rd_addr;
        ey_raddr = rd_addr;
        ez_raddr = rd_addr;
      end
      default: ;
    endcase
  end

  // control state, counters, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      k             <= '0;
      r             <= '0;
      c             <= '0;
      ph            <= '0;
      result_valid  <= 1'b0;
      h_update_gain <= H_UPDATE_GAIN_RST;
      e_decay_gain  <= E_DECAY_GAIN_RST;
      e_update_gain <= E_UPDATE_GAIN_RST;
      source_row    <= SOURCE_ROW_RST;
      source_col    <= SOURCE_COL_RST;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_H_UPDATE_GAIN: h_update_gain <= cfg_data;
          REG_E_DECAY_GAIN:  e_decay_gain  <= cfg_data;
          REG_E_UPDATE_GAIN: e_update_gain <= cfg_data;
          REG_SOURCE_ROW:    source_row    <= cfg_data[5:0];
          REG_SOURCE_COL:    source_col    <= cfg_data[5:0];
          default: ;
        endcase
      end
      case (state)
        ST_CLEAR: k <= last_cell ? '0 : k + AW'(1);
        ST_SOURCE: begin
          k  <= '0;
          r  <= '0;
          c  <= '0;
          ph <= '0;
        end
        ST_HPASS, ST_EPASS: begin
          if (cell_done) begin
            ph <= '0;
            if (last_cell) begin
              k <= '0;
              r <= '0;
              c <= '0;
            end else begin
              k <= k + AW'(1);
              if (c == CW'(GRID_COLS - 1)) begin
                c <= '0;
                r <= r + RW'(1);
              end else begin
                c <= c + CW'(1);
              end
            end
          end else begin
            ph <= ph + 4'd1;
          end
        end
        default: ;
      endcase
      if (state == ST_FINISH && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // command latch, datapath registers and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= item.command;
      src_val    <= src_clamped;
      rd_sel     <= item.field_select;
      rd_in_grid <= (32'(item.cell_row) < GRID_ROWS) && (32'(item.cell_col) < GRID_COLS);
      rd_addr    <= AW'(32'(item.cell_row) * GRID_COLS + 32'(item.cell_col));
    end
    if (state == ST_HPASS) begin
      case (ph)
        4'd1: begin hx0 <= hx_rd; ey0 <= ey_rd; ez0 <= ez_rd; end
        4'd2: begin dy <= sat_as(ey_rd, ey0, 1'b1); dz <= sat_as(ez_rd, ez0, 1'b1); end
        4'd3: curl <= sat_as(dy, dz, 1'b1);
        default: ;
      endcase
    end
    if (state == ST_EPASS) begin
      case (ph)
        4'd1: begin hx0 <= hx_rd; ey0 <= ey_rd; ez0 <= ez_rd; end
        4'd2: hz <= sat_as(hx_rd, hx0, 1'b1);
        4'd3: hy <= sat_as(hx0, hx_rd, 1'b1);
        4'd5: dey <= mul_y;
        4'd6: dez <= mul_y;
        default: ;
      endcase
    end
    if (state == ST_FINISH && out_free) begin
      result.result_kind <= (cmd == CMD_READ) ? KIND_READ : KIND_STEP;
      result.field_value <= (cmd == CMD_READ) ? rd_value : 32'sd0;
    end
  end

  // during the h sweep, h writes happen only on far edges or at the end of a cell update
  a_h_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HPASS && hx_we) |-> (h_edge || ph == 4'd7))
    else $error("hx written mid-update");

  // the phase counter never runs past the e cell length
  a_phase: assert property (@(posedge clk) disable iff (rst) ph <= 4'd8)
    else $error("phase counter overrun");

  // reset always starts the clearing pass
  a_clear: assert property (@(posedge clk) rst |=> state == ST_CLEAR)
    else $error("no clearing pass after reset");

  // no command is taken while a sweep is running
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HPASS || state == ST_EPASS || state == ST_CLEAR) |-> !item_ready)
    else $error("ready during sweep");

endmodule

@@ verif/fdtd_2d_te_grid_update_test.sv @@
`default_nettype none

module fdtd_2d_te_grid_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fdtd_pkg::*;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 3000000;

  // grid model and queue of pending results
  class grid_scoreboard;
    longint hx[ROWS][COLS];
    longint ey[ROWS][COLS];
    longint ez[ROWS][COLS];
    bit [31:0] g_h;
    bit [31:0] g_d;
    bit [31:0] g_e;
    bit [5:0] src_r;
    bit [5:0] src_c;
    result_t pending_q[$];
    int mismatches;
    int steps_done;
    int reads_done;

    function new();
      foreach (hx[r, c]) begin
        hx[r][c] = 0;
        ey[r][c] = 0;
        ez[r][c] = 0;
      end
      g_h = H_UPDATE_GAIN_RST;
      g_d = E_DECAY_GAIN_RST;
      g_e = E_UPDATE_GAIN_RST;
      src_r = SOURCE_ROW_RST;
      src_c = SOURCE_COL_RST;
      mismatches = 0;
      steps_done = 0;
      reads_done = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_H_UPDATE_GAIN: g_h = d;
        REG_E_DECAY_GAIN:  g_d = d;
        REG_E_UPDATE_GAIN: g_e = d;
        REG_SOURCE_ROW:    src_r = d[5:0];
        REG_SOURCE_COL:    src_c = d[5:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint a);
      if (a > VMAX) return VMAX;
      if (a < VMIN) return VMIN;
      return a;
    endfunction

    // unsigned q1.31 gain times value, rounded half away from zero, saturated
    function longint scale(bit [31:0] g, longint v);
      bit neg;
      bit [63:0] mag;
      bit [63:0] prod;
      neg = v < 0;
      mag = neg ? -v : v;
      prod = ({32'b0, g} * mag + 64'h4000_0000) >> 31;
      if (neg) begin
        if (prod >= 64'h8000_0000) return VMIN;
        return -longint'(prod);
      end
      if (prod > 64'h7FFF_FFFF) return VMAX;
      return longint'(prod);
    endfunction

    function void advance(longint s);
      hx[src_r][src_c] = clip(s);
      // h sweep from the curl of e
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLS - 1; c++)
          hx[r][c] = clip(hx[r][c] + scale(g_h,
                     clip(clip(ey[r][c+1] - ey[r][c]) - clip(ez[r+1][c] - ez[r][c]))));
      for (int r = 0; r < ROWS; r++) hx[r][COLS-1] = 0;
      for (int c = 0; c < COLS; c++) hx[ROWS-1][c] = 0;
      // lossy e sweep over the interior
      for (int r = 1; r < ROWS - 1; r++)
        for (int c = 1; c < COLS - 1; c++) begin
          ez[r][c] = clip(scale(g_d, ez[r][c]) + scale(g_e, clip(hx[r-1][c] - hx[r][c])));
          ey[r][c] = clip(scale(g_d, ey[r][c]) + scale(g_e, clip(hx[r][c] - hx[r][c-1])));
        end
      // pec border
      for (int r = 0; r < ROWS; r++) begin
        ey[r][0] = 0; ey[r][COLS-1] = 0;
        ez[r][0] = 0; ez[r][COLS-1] = 0;
      end
      for (int c = 0; c < COLS; c++) begin
        ey[0][c] = 0; ey[ROWS-1][c] = 0;
        ez[0][c] = 0; ez[ROWS-1][c] = 0;
      end
    endfunction

    function void note(item_t it);
      result_t e;
      longint v;
      if (it.command == CMD_STEP) begin
        advance(longint'(it.source_value));
        e.result_kind = KIND_STEP;
        e.field_value = '0;
        steps_done++;
      end else begin
        v = 0;
        case (it.field_select)
          FIELD_HX: v = hx[it.cell_row][it.cell_col];
          FIELD_EY: v = ey[it.cell_row][it.cell_col];
          FIELD_EZ: v = ez[it.cell_row][it.cell_col];
          default: v = 0;
        endcase
        e.result_kind = KIND_READ;
        e.field_value = 32'(clip(v));
        reads_done++;
      end
      pending_q.push_back(e);
    endfunction

    function void check(result_t got);
      result_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction kind=%0d value=%0d",
                   got.result_kind, got.field_value);
        return;
      end
      e = pending_q.pop_front();
      if (got.result_kind !== e.result_kind || got.field_value !== e.field_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected kind=%0d value=%0d, got kind=%0d value=%0d",
                   e.result_kind, e.field_value, got.result_kind, got.field_value);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready;
  result_t result;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  grid_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  longint cycles;

  fdtd_2d_te_grid_update uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // transaction monitors
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) sb.note(item);
    if (!rst && result_valid && result_ready) sb.check(result);
  end

  // receiver back-pressure
  always @(negedge clk) begin
    result_ready = ($urandom_range(99) >= stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic item_t step_cmd(logic [31:0] s);
    item_t it;
    it = '0;
    it.command = CMD_STEP;
    it.source_value = s;
    it.field_select = 2'($urandom_range(3));
    it.cell_row = 6'($urandom);
    it.cell_col = 6'($urandom);
    return it;
  endfunction

  function automatic item_t read_cmd(logic [1:0] f, int r, int c);
    item_t it;
    it.command = CMD_READ;
    it.source_value = $urandom;
    it.field_select = f;
    it.cell_row = 6'(r);
    it.cell_col = 6'(c);
    return it;
  endfunction

  function automatic int near(int base);
    int v;
    v = base + $urandom_range(4) - 2;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  // random mix: mostly reads, half of them around the source, at most two steps
  task automatic random_phase(int n);
    int steps_left;
    steps_left = 2;
    for (int i = 0; i < n; i++) begin
      if (steps_left > 0 && ($urandom_range(11) == 0 || i == n / 2)) begin
        send_item(step_cmd($urandom));
        steps_left--;
      end else if ($urandom_range(1))
        send_item(read_cmd(2'($urandom_range(3)), near(sb.src_r), near(sb.src_c)));
      else
        send_item(read_cmd(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63)));
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = REG_H_UPDATE_GAIN;
    cfg_data = '0;
    result_ready = 1'b1;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset values, corners, unused select, extreme sources
    send_item(read_cmd(FIELD_HX, 0, 0));
    send_item(read_cmd(FIELD_EY, 63, 63));
    send_item(read_cmd(FIELD_EZ, 0, 63));
    send_item(read_cmd(2'd3, 21, 21));
    send_item(step_cmd(32'h7FFF_FFFF));
    send_item(read_cmd(FIELD_HX, 21, 21));
    send_item(read_cmd(FIELD_HX, 20, 21));
    send_item(read_cmd(FIELD_EY, 21, 21));
    send_item(read_cmd(FIELD_EY, 21, 22));
    send_item(read_cmd(FIELD_EZ, 21, 21));
    send_item(read_cmd(FIELD_EZ, 22, 21));
    send_item(read_cmd(2'd3, 63, 0));
    send_item(step_cmd(32'h8000_0000));
    send_item(read_cmd(FIELD_HX, 21, 21));
    send_item(read_cmd(FIELD_HX, 21, 20));
    send_item(read_cmd(FIELD_EY, 20, 21));
    send_item(read_cmd(FIELD_EZ, 20, 20));
    send_item(read_cmd(FIELD_EY, 0, 21));
    send_item(read_cmd(FIELD_HX, 63, 21));
    random_phase(12);
    drain();

    // full gains, source on the far hx corner which gets cleared
    write_reg(REG_H_UPDATE_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_E_DECAY_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_E_UPDATE_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_SOURCE_ROW, 32'd63);
    write_reg(REG_SOURCE_COL, 32'd63);
    send_idle_pct = 48;
    send_item(read_cmd(FIELD_HX, 63, 63));
    random_phase(22);
    send_item(read_cmd(FIELD_HX, 63, 63));
    send_item(read_cmd(FIELD_HX, 62, 62));
    drain();

    // zero gains, source at the origin
    write_reg(REG_H_UPDATE_GAIN, 32'h0);
    write_reg(REG_E_DECAY_GAIN, 32'h0);
    write_reg(REG_E_UPDATE_GAIN, 32'h0);
    write_reg(REG_SOURCE_ROW, 32'd0);
    write_reg(REG_SOURCE_COL, 32'd0);
    send_idle_pct = 0;
    stall_pct = 48;
    random_phase(22);
    send_item(read_cmd(FIELD_HX, 0, 0));
    drain();

    // random gains and source cell
    write_reg(REG_H_UPDATE_GAIN, $urandom);
    write_reg(REG_E_DECAY_GAIN, $urandom);
    write_reg(REG_E_UPDATE_GAIN, $urandom);
    write_reg(REG_SOURCE_ROW, $urandom_range(1, 62));
    write_reg(REG_SOURCE_COL, $urandom_range(1, 62));
    send_idle_pct = 31;
    stall_pct = 31;
    random_phase(22);
    drain();
    repeat (50) @(negedge clk);

    $display("covered %0d grid steps and %0d cell reads over four gain/source settings",
             sb.steps_done, sb.reads_done);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/fdtd_pkg.sv
src/fdtd_grid_ram.sv
src/fdtd_gmul.sv
src/fdtd_2d_te_grid_update.sv
verif/fdtd_2d_te_grid_update_test.sv
